// ===== rtl/stdf_pkg.sv =====
// Shared types, constants and the display character mapping of the text feeder.
package stdf_pkg;

  localparam int DIGITS_DEF   = 12;
  localparam int BUF_SIZE_DEF = 64;

  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 9;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int QDEPTH     = 2;

  localparam logic [CHAR_W-1:0] CMD_RESET  = 8'd16;
  localparam logic [CHAR_W-1:0] CODE_BLANK = 8'd79;
  localparam logic [TICK_W-1:0] MAG_MAX    = 8'd255;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL_MODE = 2'd0,
    CFG_RAM_CMD     = 2'd1,
    CFG_SPARE2      = 2'd2,
    CFG_SPARE3      = 2'd3
  } cfg_idx_t;

  // ASCII to display character set; anything unmapped shows the blank code.
  function automatic logic [CHAR_W-1:0] map_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = CODE_BLANK;
    if (c >= 8'd64 && c <= 8'd95) begin
      r = c - 8'd48;
    end else if (c >= 8'd32 && c <= 8'd63) begin
      r = c + 8'd16;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = c - 8'd80;
    end
    return r;
  endfunction

endpackage

// ===== rtl/stdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/stdf_queue.sv =====
// Small FIFO of frame requests between the front and back parts.
module stdf_queue
  import stdf_pkg::*;
#(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] slot_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/stdf_front.sv =====
// Front part: takes words, loads text, counts ticks and queues frame requests.
module stdf_front
  import stdf_pkg::*;
#(
  parameter int DIGITS   = DIGITS_DEF,
  parameter int BUF_SIZE = BUF_SIZE_DEF,
  localparam int AW = $clog2(BUF_SIZE),
  localparam int PW = $clog2((DIGITS > BUF_SIZE) ? DIGITS : BUF_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            kind,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [CHAR_W-1:0]     ram_wdata,
  output logic                  push,
  output logic [PW+AW-1:0]      push_data,
  output logic [CHAR_W-1:0]     ram_cmd
);

  logic [AW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     len_r, len_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CHAR_W-1:0] cmd_r, cmd_nxt;

  logic              neg;
  logic [MODE_W-1:0] mag9;
  logic [TICK_W-1:0] mag;
  logic [TICK_W-1:0] tick_inc;
  logic [PW-1:0]     len_ext;
  logic [PW-1:0]     pos_fwd;
  logic [PW-1:0]     push_pos;
  logic [AW-1:0]     push_len;

  assign neg      = mode_r[MODE_W-1];
  assign mag9     = neg ? (~mode_r + 1'b1) : mode_r;
  assign mag      = mag9[MODE_W-1] ? MAG_MAX : mag9[TICK_W-1:0];
  assign tick_inc = tick_r + 1'b1;
  assign len_ext  = PW'(len_r);
  assign pos_fwd  = pos_r + 1'b1;

  assign ram_waddr = fill_r;
  assign ram_wdata = char_code;
  assign ram_cmd   = cmd_r;
  assign push_data = {push_pos, push_len};

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    tick_nxt = tick_r;
    mode_nxt = mode_r;
    cmd_nxt  = cmd_r;
    ram_we   = 1'b0;
    push     = 1'b0;
    push_pos = pos_r;
    push_len = len_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCROLL_MODE: begin
          mode_nxt = cfg_data;
          tick_nxt = '0;
        end
        CFG_RAM_CMD: cmd_nxt = cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      unique case (kind)
        KIND_CHAR: begin
          if (fill_r < AW'(BUF_SIZE - 1)) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        KIND_END: begin
          len_nxt  = fill_r;
          fill_nxt = '0;
          pos_nxt  = (fill_r != '0) ? PW'(DIGITS - 1) : '0;
          push     = 1'b1;
          push_pos = pos_nxt;
          push_len = fill_r;
        end
        KIND_TICK: begin
          if (mode_r == '0) begin
            tick_nxt = '0;
          end else if (tick_inc < mag) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt = '0;
            push     = 1'b1;
            // step the window after the frame has been queued
            if (len_r == '0) begin
              pos_nxt = '0;
            end else if (!neg) begin
              pos_nxt = (pos_fwd >= len_ext) ? '0 : pos_fwd;
            end else begin
              pos_nxt = (pos_r == '0) ? (len_ext - 1'b1) : (pos_r - 1'b1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      pos_r  <= '0;
      tick_r <= '0;
      mode_r <= '0;
      cmd_r  <= CMD_RESET;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      tick_r <= tick_nxt;
      mode_r <= mode_nxt;
      cmd_r  <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/stdf_back.sv =====
// Back part: plays one queued frame out as a command word and digit codes.
module stdf_back
  import stdf_pkg::*;
#(
  parameter int DIGITS   = DIGITS_DEF,
  parameter int BUF_SIZE = BUF_SIZE_DEF,
  localparam int AW = $clog2(BUF_SIZE),
  localparam int PW = $clog2((DIGITS > BUF_SIZE) ? DIGITS : BUF_SIZE),
  localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [PW+AW-1:0]  q_data,
  output logic              q_pop,
  input  logic [CHAR_W-1:0] ram_cmd,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CHAR_W-1:0] ram_rdata,
  output logic              active,
  output logic              out_strobe,
  output logic [CHAR_W-1:0] out_byte,
  output logic              out_is_command,
  output logic              out_last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMD   = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CHAR_W-1:0] byte_r, byte_nxt;
  logic              cmd_flag_r, cmd_flag_nxt;
  logic              last_r, last_nxt;

  logic [PW-1:0] len_ext;
  logic [PW-1:0] p_step;
  logic          hit_now;

  assign len_ext   = PW'(len_r);
  assign hit_now   = (p_r < len_ext);
  assign p_step    = (p_r != '0) ? (p_r - 1'b1) :
                     ((len_r != '0) ? (len_ext - 1'b1) : '0);
  assign ram_raddr = p_r[AW-1:0];
  assign active    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    p_nxt        = p_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    hit_nxt      = hit_r;
    strobe_nxt   = 1'b0;
    byte_nxt     = byte_r;
    cmd_flag_nxt = 1'b0;
    last_nxt     = 1'b0;
    q_pop        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          p_nxt     = q_data[PW+AW-1:AW];
          len_nxt   = q_data[AW-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        strobe_nxt   = 1'b1;
        byte_nxt     = ram_cmd;
        cmd_flag_nxt = 1'b1;
        hit_nxt      = hit_now;
        p_nxt        = p_step;
        state_nxt    = ST_DIGIT;
      end
      ST_DIGIT: begin
        strobe_nxt = 1'b1;
        byte_nxt   = hit_r ? map_code(ram_rdata) : CODE_BLANK;
        if (cnt_r == CW'(DIGITS - 1)) begin
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          hit_nxt = hit_now;
          p_nxt   = p_step;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      strobe_r   <= 1'b0;
      cmd_flag_r <= 1'b0;
      last_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      strobe_r   <= strobe_nxt;
      cmd_flag_r <= cmd_flag_nxt;
      last_r     <= last_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    len_r  <= len_nxt;
    hit_r  <= hit_nxt;
    byte_r <= byte_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_byte       = byte_r;
  assign out_is_command = cmd_flag_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/scrolling_text_display_feeder.sv =====
// Top level of the scrolling text feeder for a multi-digit character display.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | start / busy              | in_kind, in_char_code
//   result   | out_strobe (no back-off)  | out_byte, out_is_command, out_last
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A text character or a tick that does not complete a period leaves busy low.
// An end-of-text word, or a tick that completes a period, queues one frame: the
// back part pops it, and the DIGITS+1 result words, registered from its command
// and digit states, follow back to back, one text store read per cycle.
// Busy stays high while a frame is queued or playing out, so the text store
// is never rewritten under a frame that still reads it.
// Reset (rst_n low at a clock edge) clears the front part's lengths, counters,
// position and registers; the text store is not cleared and needs no clearing.
// The result side cannot stall; every word is shown for exactly one cycle.
module scrolling_text_display_feeder
  import stdf_pkg::*;
#(
  parameter int DIGITS   = DIGITS_DEF,
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  // result words
  output logic                  out_strobe,
  output logic [CHAR_W-1:0]     out_byte,
  output logic                  out_is_command,
  output logic                  out_last,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int PW = $clog2((DIGITS > BUF_SIZE) ? DIGITS : BUF_SIZE);
  localparam int QW = PW + AW;

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic              q_push, q_pop, q_empty, q_full;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic [CHAR_W-1:0] ram_cmd;
  logic              back_active;

  // Hold off new words while any frame is outstanding.
  assign busy      = q_full || !q_empty || back_active;
  assign accept    = start && !busy;
  // Registers are always writable; writing only while idle is up to the user.
  assign cfg_ready = 1'b1;

  stdf_front #(
    .DIGITS   (DIGITS),
    .BUF_SIZE (BUF_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_kind),
    .char_code (in_char_code),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (q_push),
    .push_data (q_wdata),
    .ram_cmd   (ram_cmd)
  );

  // Frame requests carry the window position and text length at issue.
  stdf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  stdf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_SIZE)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stdf_back #(
    .DIGITS   (DIGITS),
    .BUF_SIZE (BUF_SIZE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .ram_cmd        (ram_cmd),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .active         (back_active),
    .out_strobe     (out_strobe),
    .out_byte       (out_byte),
    .out_is_command (out_is_command),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/stdf_checker.sv =====
// Port-level checks on the text feeder, bound to the top level.
module stdf_checker
  import stdf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_strobe,
  input logic       out_is_command,
  input logic       out_last
);

  // A command word is always followed by a digit code.
  a_cmd_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_command |=> out_strobe && !out_is_command)
    else $error("command word not followed by a digit code");

  // The frame end flag marks a digit code only.
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe && !out_is_command)
    else $error("last flag outside a digit code");

  // An accepted end of text holds off the next word while its frame runs.
  a_end_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_END |=> busy)
    else $error("end of text accepted without busy");

  // A frame's last word leaves a gap before any further word.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("word directly after the end of a frame");

endmodule

bind scrolling_text_display_feeder stdf_checker u_stdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .out_strobe     (out_strobe),
  .out_is_command (out_is_command),
  .out_last       (out_last)
);
